[rtl/core/upr_pkg.sv]
package upr_pkg;

    // Counter width shared by the tick counter and the echo width counter
    localparam int TIME_BITS       = 24;
    localparam int TRIG_LOW_TICKS  = 2;
    localparam int TRIG_HIGH_TICKS = 10;
    localparam int CM_DIVISOR      = 58;
    localparam int REM_BITS        = $clog2(CM_DIVISOR);

    localparam longint unsigned TIME_MAX_L = (64'd1 << TIME_BITS) - 64'd1;
    localparam int QUOT_BITS = $clog2(TIME_MAX_L / CM_DIVISOR + 1);

    // Configuration register widths and indexes
    localparam int TIMER_CFG_BITS = 24;
    localparam int DIST_BITS      = 16;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [CFG_ADDR_BITS-1:0] REG_ECHO_TIMEOUT  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_MIN    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_MAX    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CONFIRM_DELAY = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HOLD_OFF      = 3'd4;

    localparam logic [TIMER_CFG_BITS-1:0] ECHO_TIMEOUT_RST  = 24'd2000000;
    localparam logic [DIST_BITS-1:0]      WINDOW_MIN_RST    = 16'd2;
    localparam logic [DIST_BITS-1:0]      WINDOW_MAX_RST    = 16'd50;
    localparam logic [TIMER_CFG_BITS-1:0] CONFIRM_DELAY_RST = 24'd500000;
    localparam logic [TIMER_CFG_BITS-1:0] HOLD_OFF_RST      = 24'd5000000;

    // Stream widths
    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_DATA_BITS = 24;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef struct packed {
        logic [TIMER_CFG_BITS-1:0] echo_timeout_us;
        logic [DIST_BITS-1:0]      window_min_cm;
        logic [DIST_BITS-1:0]      window_max_cm;
        logic [TIMER_CFG_BITS-1:0] confirm_delay_us;
        logic [TIMER_CFG_BITS-1:0] hold_off_us;
    } cfg_t;

    typedef struct packed {
        logic                 presence;
        logic [DIST_BITS-1:0] distance_cm;
        logic                 timed_out;
        logic                 reading_done;
        logic                 trigger_level;
    } result_t;

    typedef enum logic [5:0] {
        PH_TRIG_LOW  = 6'b000001,
        PH_TRIG_HIGH = 6'b000010,
        PH_WAIT_RISE = 6'b000100,
        PH_MEASURE   = 6'b001000,
        PH_CONFIRM   = 6'b010000,
        PH_HOLD      = 6'b100000
    } phase_t;

    // Limit a threshold to the largest count the tick counter can hold
    function automatic time_t clip_time(input logic [31:0] v);
        time_t r;
        if (64'(v) > TIME_MAX_L) begin
            r = '1;
        end else begin
            r = v[TIME_BITS-1:0];
        end
        return r;
    endfunction

    // Saturating increment of a tick count
    function automatic time_t sat_inc(input time_t v);
        time_t r;
        if (v == '1) begin
            r = v;
        end else begin
            r = v + 1'b1;
        end
        return r;
    endfunction

endpackage

[rtl/core/upr_ranger.sv]
module upr_ranger (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic            echo_level,
    input  upr_pkg::cfg_t    cfg,
    output upr_pkg::result_t result
);
    import upr_pkg::*;

    phase_t                phase_reg, phase_next;
    time_t                 ticks_reg, ticks_next;
    time_t                 width_reg, width_next;
    logic [QUOT_BITS-1:0]  quot_reg, quot_next;
    logic [REM_BITS-1:0]   rem_reg, rem_next;
    logic                  confirming_reg, confirming_next;
    logic [DIST_BITS-1:0]  last_dist_reg, last_dist_next;

    // Advance the ranging sequence by one tick
    always_comb begin
        time_t                ticks_inc;
        time_t                limit;
        logic                 judge_en;
        logic                 near;
        logic [DIST_BITS-1:0] dist_cm;

        ticks_inc       = sat_inc(ticks_reg);
        limit           = '0;
        judge_en        = 1'b0;
        near            = 1'b0;
        dist_cm         = '0;
        phase_next      = phase_reg;
        ticks_next      = ticks_reg;
        width_next      = width_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        confirming_next = confirming_reg;
        last_dist_next  = last_dist_reg;
        result          = '0;

        case (phase_reg)
            PH_TRIG_LOW: begin
                ticks_next = ticks_inc;
                if (ticks_inc >= clip_time(32'(TRIG_LOW_TICKS))) begin
                    phase_next = PH_TRIG_HIGH;
                    ticks_next = '0;
                end
            end
            PH_TRIG_HIGH: begin
                result.trigger_level = 1'b1;
                ticks_next = ticks_inc;
                if (ticks_inc >= clip_time(32'(TRIG_HIGH_TICKS))) begin
                    phase_next = PH_WAIT_RISE;
                    ticks_next = '0;
                end
            end
            PH_WAIT_RISE: begin
                if (echo_level) begin
                    // Start the echo count at one tick: quotient 0, remainder 1
                    width_next = time_t'(1);
                    quot_next  = '0;
                    rem_next   = REM_BITS'(1);
                    phase_next = PH_MEASURE;
                    ticks_next = '0;
                end else begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= clip_time(32'(cfg.echo_timeout_us))) begin
                        result.reading_done = 1'b1;
                        result.timed_out    = 1'b1;
                        last_dist_next      = '0;
                        judge_en            = 1'b1;
                        near                = 1'b0;
                    end
                end
            end
            PH_MEASURE: begin
                if (echo_level) begin
                    // Keep a running quotient and remainder by the divisor
                    if (width_reg != '1) begin
                        width_next = width_reg + 1'b1;
                        if (rem_reg == REM_BITS'(CM_DIVISOR - 1)) begin
                            rem_next  = '0;
                            quot_next = quot_reg + 1'b1;
                        end else begin
                            rem_next = rem_reg + 1'b1;
                        end
                    end
                end else begin
                    if (32'(quot_reg) > 32'(16'hFFFF)) begin
                        dist_cm = '1;
                    end else begin
                        dist_cm = DIST_BITS'(quot_reg);
                    end
                    last_dist_next      = dist_cm;
                    result.reading_done = 1'b1;
                    judge_en            = 1'b1;
                    near = (dist_cm > cfg.window_min_cm) && (dist_cm < cfg.window_max_cm);
                end
            end
            PH_CONFIRM, PH_HOLD: begin
                if (phase_reg == PH_CONFIRM) begin
                    limit = clip_time(32'(cfg.confirm_delay_us));
                end else begin
                    limit = clip_time(32'(cfg.hold_off_us));
                end
                ticks_next = ticks_inc;
                if (ticks_inc >= limit) begin
                    phase_next = PH_TRIG_LOW;
                    ticks_next = '0;
                end
            end
            default: begin
                // Restart the cycle in trigger low with one tick already counted
                phase_next = PH_TRIG_LOW;
                ticks_next = time_t'(1);
            end
        endcase

        // Decide what follows a finished reading
        if (judge_en) begin
            ticks_next = '0;
            if (!confirming_reg) begin
                confirming_next = near;
                phase_next      = near ? PH_CONFIRM : PH_TRIG_LOW;
            end else begin
                confirming_next = 1'b0;
                result.presence = near;
                phase_next      = near ? PH_HOLD : PH_TRIG_LOW;
            end
        end

        result.distance_cm = last_dist_next;
    end

    // Hold state until a tick is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_TRIG_LOW;
            ticks_reg      <= '0;
            width_reg      <= '0;
            quot_reg       <= '0;
            rem_reg        <= '0;
            confirming_reg <= 1'b0;
            last_dist_reg  <= '0;
        end else if (step) begin
            phase_reg      <= phase_next;
            ticks_reg      <= ticks_next;
            width_reg      <= width_next;
            quot_reg       <= quot_next;
            rem_reg        <= rem_next;
            confirming_reg <= confirming_next;
            last_dist_reg  <= last_dist_next;
        end
    end

endmodule

[rtl/core/ultrasonic_presence_ranger.sv]
// Ultrasonic presence ranger: drives the trigger of an ultrasonic sensor and
// measures the echo, one input transaction per microsecond tick.
// s_ channel: one transaction per tick carrying the sampled echo level.
// m_ channel: exactly one transaction per input tick with the trigger level to
// drive, a reading-done pulse, a timeout flag, the last distance in cm and a
// presence pulse when two successive readings fall inside the window.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 echo
// timeout, 1 window min, 2 window max, 3 confirm delay, 4 hold-off); other
// addresses are ignored. Write only while the block is idle.
// Flow: an accepted tick waits in the input register and is processed into the
// result register once that register is free or its result is being taken.
// Throughput: one tick per cycle while m_tready stays high, through the state
// update between the input register and the result register.
// Reset (aresetn low, synchronous) returns the sequence to trigger low, clears
// the reading state and loads the register defaults.
// When m_tready is low the result register holds and the input register still
// takes one more tick; s_tready then drops until the result is taken.
module ultrasonic_presence_ranger (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [upr_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [upr_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    // Input ticks
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [upr_pkg::IN_DATA_BITS-1:0]     s_tdata,   // [0] echo_level
    // Results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] trigger_level, [1] reading_done, [2] timed_out, [18:3] distance_cm,
    // [19] presence, [23:20] zero
    output logic [upr_pkg::OUT_DATA_BITS-1:0]    m_tdata
);
    import upr_pkg::*;

    cfg_t    cfg_reg;
    result_t result;
    logic    in_valid_reg;
    logic    in_echo_reg;
    logic    out_valid_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg;
    logic    advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.echo_timeout_us  <= ECHO_TIMEOUT_RST;
            cfg_reg.window_min_cm    <= WINDOW_MIN_RST;
            cfg_reg.window_max_cm    <= WINDOW_MAX_RST;
            cfg_reg.confirm_delay_us <= CONFIRM_DELAY_RST;
            cfg_reg.hold_off_us      <= HOLD_OFF_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_ECHO_TIMEOUT:  cfg_reg.echo_timeout_us  <= cfg_wdata[TIMER_CFG_BITS-1:0];
                REG_WINDOW_MIN:    cfg_reg.window_min_cm    <= cfg_wdata[DIST_BITS-1:0];
                REG_WINDOW_MAX:    cfg_reg.window_max_cm    <= cfg_wdata[DIST_BITS-1:0];
                REG_CONFIRM_DELAY: cfg_reg.confirm_delay_us <= cfg_wdata[TIMER_CFG_BITS-1:0];
                REG_HOLD_OFF:      cfg_reg.hold_off_us      <= cfg_wdata[TIMER_CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Process the held tick when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_echo_reg <= s_tdata[0];
        end
    end

    upr_ranger u_ranger (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .echo_level (in_echo_reg),
        .cfg        (cfg_reg),
        .result     (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= OUT_DATA_BITS'(result);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[sim/ranger_checker.sv]
module ranger_checker
    import upr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [IN_DATA_BITS-1:0]   s_tdata,   // [0] echo_level
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    // [0] trigger_level, [1] reading_done, [2] timed_out, [18:3] distance_cm,
    // [19] presence, [23:20] zero
    input  logic [OUT_DATA_BITS-1:0]  m_tdata,
    output int unsigned               mismatch_count,
    output int unsigned               pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the configuration registers
    logic [TIMER_CFG_BITS-1:0] timeout_us;
    logic [DIST_BITS-1:0]      near_min_cm;
    logic [DIST_BITS-1:0]      near_max_cm;
    logic [TIMER_CFG_BITS-1:0] confirm_us;
    logic [TIMER_CFG_BITS-1:0] hold_us;

    // Shadow copy of the ranging sequence
    phase_t               phase;
    time_t                phase_ticks;
    time_t                echo_ticks;
    logic                 confirming;
    logic [DIST_BITS-1:0] last_cm;

    // Tick results predicted but not yet seen on the result channel
    result_t tick_results_q[$];

    // Saturating tick count
    function automatic time_t bump(input time_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic enter(input phase_t next);
        phase       = next;
        phase_ticks = '0;
    endtask

    // Route a finished reading: first reading starts confirmation, second decides
    task automatic close_reading(input logic near, output logic presence);
        presence = 1'b0;
        if (!confirming) begin
            if (near) begin
                confirming = 1'b1;
                enter(PH_CONFIRM);
            end else begin
                enter(PH_TRIG_LOW);
            end
        end else begin
            confirming = 1'b0;
            if (near) begin
                presence = 1'b1;
                enter(PH_HOLD);
            end else begin
                enter(PH_TRIG_LOW);
            end
        end
    endtask

    // Advance the sequence by one microsecond tick and form its result
    task automatic predict_tick(input logic echo, output result_t r);
        time_t cm;
        logic  pres;
        r    = '0;
        pres = 1'b0;
        case (phase)
            PH_TRIG_HIGH: begin
                r.trigger_level = 1'b1;
                phase_ticks = bump(phase_ticks);
                if (phase_ticks >= time_t'(TRIG_HIGH_TICKS)) enter(PH_WAIT_RISE);
            end
            PH_WAIT_RISE: begin
                if (echo) begin
                    echo_ticks = time_t'(1);
                    enter(PH_MEASURE);
                end else begin
                    phase_ticks = bump(phase_ticks);
                    // a zero timeout still waits one tick
                    if (phase_ticks >= timeout_us) begin
                        r.reading_done = 1'b1;
                        r.timed_out    = 1'b1;
                        last_cm        = '0;
                        close_reading(1'b0, pres);
                    end
                end
            end
            PH_MEASURE: begin
                if (echo) begin
                    echo_ticks = bump(echo_ticks);
                end else begin
                    cm = echo_ticks / CM_DIVISOR;
                    last_cm = (cm > time_t'(16'hFFFF)) ? '1 : cm[DIST_BITS-1:0];
                    r.reading_done = 1'b1;
                    close_reading(last_cm > near_min_cm && last_cm < near_max_cm, pres);
                end
            end
            PH_CONFIRM: begin
                phase_ticks = bump(phase_ticks);
                if (phase_ticks >= confirm_us) enter(PH_TRIG_LOW);
            end
            PH_HOLD: begin
                phase_ticks = bump(phase_ticks);
                if (phase_ticks >= hold_us) enter(PH_TRIG_LOW);
            end
            default: begin
                phase_ticks = bump(phase_ticks);
                if (phase_ticks >= time_t'(TRIG_LOW_TICKS)) enter(PH_TRIG_HIGH);
            end
        endcase
        r.distance_cm = last_cm;
        r.presence    = pres;
    endtask

    task automatic check_field(input string field, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // Track configuration, predict accepted ticks, compare accepted results
    always @(posedge aclk) begin : watch
        result_t want;
        result_t got;
        if (!aresetn) begin
            timeout_us   = ECHO_TIMEOUT_RST;
            near_min_cm  = WINDOW_MIN_RST;
            near_max_cm  = WINDOW_MAX_RST;
            confirm_us   = CONFIRM_DELAY_RST;
            hold_us      = HOLD_OFF_RST;
            phase        = PH_TRIG_LOW;
            phase_ticks  = '0;
            echo_ticks   = '0;
            confirming   = 1'b0;
            last_cm      = '0;
            tick_results_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ECHO_TIMEOUT:  timeout_us  = cfg_wdata[TIMER_CFG_BITS-1:0];
                    REG_WINDOW_MIN:    near_min_cm = cfg_wdata[DIST_BITS-1:0];
                    REG_WINDOW_MAX:    near_max_cm = cfg_wdata[DIST_BITS-1:0];
                    REG_CONFIRM_DELAY: confirm_us  = cfg_wdata[TIMER_CFG_BITS-1:0];
                    REG_HOLD_OFF:      hold_us     = cfg_wdata[TIMER_CFG_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_tick(s_tdata[0], want);
                tick_results_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (tick_results_q.size() == 0) begin
                    $error("result transaction with no tick waiting: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = tick_results_q.pop_front();
                    check_field("trigger_level", 32'(want.trigger_level),
                                32'(got.trigger_level));
                    check_field("reading_done", 32'(want.reading_done),
                                32'(got.reading_done));
                    check_field("timed_out", 32'(want.timed_out), 32'(got.timed_out));
                    check_field("distance_cm", 32'(want.distance_cm),
                                32'(got.distance_cm));
                    check_field("presence", 32'(want.presence), 32'(got.presence));
                    check_field("padding", 0,
                                32'(m_tdata[OUT_DATA_BITS-1:$bits(result_t)]));
                end
            end
        end
        pending_results = tick_results_q.size();
    end

endmodule

[sim/ultrasonic_presence_ranger_tb.sv]
module ultrasonic_presence_ranger_tb;
    import upr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0]  cfg_addr  = REG_ECHO_TIMEOUT;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b1;
    logic [OUT_DATA_BITS-1:0]  m_tdata;

    int unsigned mismatch_count;
    int unsigned pending_results;
    int unsigned sent_ticks = 0;
    logic        quiet      = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    ultrasonic_presence_ranger i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ranger_checker i_ranger_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Stall the result channel at random unless in a quiet stretch
    always @(negedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 10);
    end

    // Offer one echo sample and wait for its transaction
    task automatic send_tick(input logic echo);
        while (!quiet && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_BITS'(echo);
        do @(posedge aclk); while (!s_tready);
        sent_ticks++;
        @(negedge aclk);
    endtask

    // Low gap, then an echo pulse whose width decodes to the given distance
    task automatic send_pulse(input int unsigned gap, input int unsigned cm);
        int unsigned width;
        width = (cm == 0) ? $urandom_range(CM_DIVISOR - 1, 1)
                          : cm * CM_DIVISOR + $urandom_range(CM_DIVISOR - 1);
        repeat (gap) send_tick(1'b0);
        repeat (width) send_tick(1'b1);
    endtask

    task automatic send_noise(input int unsigned count);
        int unsigned pct;
        pct = $urandom_range(90, 20);
        repeat (count) send_tick($urandom_range(99) < pct);
    endtask

    // Hold the stream until every tick result is back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write all registers while idle, plus one write to an unused index
    task automatic load_config(input logic [TIMER_CFG_BITS-1:0] timeout,
                               input logic [DIST_BITS-1:0] wmin,
                               input logic [DIST_BITS-1:0] wmax,
                               input logic [TIMER_CFG_BITS-1:0] confirm,
                               input logic [TIMER_CFG_BITS-1:0] hold);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_ECHO_TIMEOUT;
        cfg_wdata <= timeout;
        @(negedge aclk);
        cfg_addr  <= REG_WINDOW_MIN;
        cfg_wdata <= {8'($urandom), wmin};
        @(negedge aclk);
        cfg_addr  <= REG_WINDOW_MAX;
        cfg_wdata <= {8'($urandom), wmax};
        @(negedge aclk);
        cfg_addr  <= REG_CONFIRM_DELAY;
        cfg_wdata <= confirm;
        @(negedge aclk);
        cfg_addr  <= REG_HOLD_OFF;
        cfg_wdata <= hold;
        @(negedge aclk);
        cfg_addr  <= REG_HOLD_OFF + CFG_ADDR_BITS'($urandom_range(3, 1));
        cfg_wdata <= CFG_DATA_BITS'($urandom);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned c_us;
        int unsigned h_us;
        int unsigned gap;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: zero timeout acts as one tick, echo ignored while triggering,
        // shortest possible echo pulse
        load_config(24'd0, 16'd0, 16'hFFFF, 24'd0, 24'd0);
        repeat (12) send_tick(1'b1);
        send_tick(1'b0);
        repeat (12) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // Narrow window with no waits: presence on two readings of 1 or 2 cm
        load_config(24'd40, 16'd0, 16'd3, 24'd0, 24'd0);
        while (sent_ticks < 420) begin
            gap = ($urandom_range(7) == 0) ? 60 + $urandom_range(20)
                                           : 16 + $urandom_range(6);
            send_pulse(gap, $urandom_range(3));
        end

        // Shortest timeout, unreachable window, longest delays: noise only
        load_config(24'd1, 16'hFFFF, 16'd0, 24'hFFFFFF, 24'hFFFFFF);
        while (sent_ticks < 540) send_noise(40);

        // Longest timeout, window edges, random delays, no idling on either side
        c_us = $urandom_range(20, 1);
        h_us = $urandom_range(30, 1);
        load_config(24'hFFFFFF, 16'd1, 16'd4, TIMER_CFG_BITS'(c_us),
                    TIMER_CFG_BITS'(h_us));
        quiet = 1'b1;
        while (sent_ticks < 1000) begin
            send_pulse(14 + c_us + h_us + $urandom_range(8), $urandom_range(5));
        end
        quiet = 1'b0;

        // Wide window, short waits, occasional timeouts
        load_config(24'd30, 16'd0, 16'hFFFF, 24'd2, 24'd5);
        while (sent_ticks < 1350) begin
            gap = ($urandom_range(5) == 0) ? 50 + $urandom_range(10)
                                           : 21 + $urandom_range(8);
            send_pulse(gap, $urandom_range(3));
        end

        // Broken sequences: random echo levels with varying density
        load_config(24'd8, 16'd0, 16'd2, 24'd1, 24'd0);
        while (sent_ticks < 1680) send_noise(50);

        drain();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Abort a hung run
    initial begin : watchdog
        #2ms;
        $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/upr_pkg.sv
rtl/core/upr_ranger.sv
rtl/core/ultrasonic_presence_ranger.sv
sim/ranger_checker.sv
sim/ultrasonic_presence_ranger_tb.sv
